// ===== hdl/diffusion_stencil_rhs_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Diffusion stencil RHS assertion macros
// Shared concurrent-check wrappers. Every check is clocked on clk and held
// off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DIFFUSION_STENCIL_RHS_UNIT_ASSERT_SVH
`define DIFFUSION_STENCIL_RHS_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define DSR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define DSR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/dsr_pkg.sv =====
// ----------------------------------------------------------------------------
// dsr_pkg
// Widths, register codes, reset values and the constant functions that build
// the sine and source-amplitude tables of the diffusion stencil RHS unit.
// ----------------------------------------------------------------------------
package dsr_pkg;

	// field widths
	localparam int VAL_W   = 32;             // stencil values, signed Q16
	localparam int IDX_W   = 6;              // row / column index
	localparam int ROM_SIZE = 1 << IDX_W;
	localparam int COEF_W  = 24;             // wide config registers
	localparam int HX_W    = 16;             // two_hx register
	localparam int RATE_W  = 48;             // saturated result
	localparam int Q_FRAC  = 16;             // fractional bits

	// datapath widths
	localparam int TRIG_W  = 18;             // signed Q16 sine, [-1, 1]
	localparam int AMP_W   = 18;             // unsigned Q16 amplitude, [0, 3]
	localparam int NEUM_W  = 18;             // two_hx * sine, Q16
	localparam int SRC_W   = 19;             // amp * sine, Q16
	localparam int LX_W    = 35;             // ul - 2c + ur
	localparam int LY_W    = 34;             // up - 2c + down
	localparam int PX_W    = LX_W + COEF_W + 1;
	localparam int PY_W    = LY_W + COEF_W + 1;
	localparam int SUM_W   = PX_W;
	localparam int MAG_W   = SUM_W - 1;
	localparam int LO_W    = 32;
	localparam int HI_W    = MAG_W - LO_W;
	localparam int PH_W    = COEF_W + HI_W;
	localparam int PL_W    = COEF_W + LO_W;
	localparam int Q_W     = LO_W + Q_FRAC + 1;

	// input accept to result strobe
	localparam int LAT     = 9;

	// register reset values
	localparam logic [COEF_W-1:0] DIFF_RST   = 24'd65536;
	localparam logic [COEF_W-1:0] INV_HX_RST = 24'd3969;
	localparam logic [COEF_W-1:0] INV_HY_RST = 24'd4096;
	localparam logic [HX_W-1:0]   TWO_HX_RST = 16'd2080;

	// saturation limits
	localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
	localparam logic signed [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

	// table build constants, Q30
	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] X_PEAK_Q30  = 64'd644245094;

	typedef enum logic [1:0] {
		CFG_DIFF   = 2'd0,
		CFG_INV_HX = 2'd1,
		CFG_INV_HY = 2'd2,
		CFG_TWO_HX = 2'd3
	} cfg_idx_t;

	// scaled Laplacian in sign-magnitude form
	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
	} mag_t;

	// sin of a Q32 phase in turns, Q16 result; quarter-wave fold + Taylor
	function automatic logic signed [TRIG_W-1:0] sine_q16(input logic [63:0] p);
		logic [63:0] quad;
		logic [63:0] frac;
		logic [63:0] t;
		logic [63:0] a;
		logic [63:0] a2;
		logic [63:0] term;
		logic [63:0] m;
		logic signed [63:0] sum;
		logic signed [TRIG_W-1:0] ms;
		quad = (p >> 30) & 64'd3;
		frac = p & (Q30_ONE - 64'd1);
		t    = quad[0] ? Q30_ONE - frac : frac;
		a    = (t * HALF_PI_Q30) >> 30;
		a2   = (a * a) >> 30;
		term = a;
		sum  = $signed(a);
		term = ((term * a2) >> 30) / 64'd6;   sum = sum - $signed(term);
		term = ((term * a2) >> 30) / 64'd20;  sum = sum + $signed(term);
		term = ((term * a2) >> 30) / 64'd42;  sum = sum - $signed(term);
		term = ((term * a2) >> 30) / 64'd72;  sum = sum + $signed(term);
		term = ((term * a2) >> 30) / 64'd110; sum = sum - $signed(term);
		term = ((term * a2) >> 30) / 64'd156; sum = sum + $signed(term);
		term = ((term * a2) >> 30) / 64'd210; sum = sum - $signed(term);
		if (sum < 0)
			sum = 0;
		if (sum > $signed(Q30_ONE))
			sum = $signed(Q30_ONE);
		m  = ($unsigned(sum) + 64'd8192) >> 14;
		ms = TRIG_W'(m);
		return (quad >= 64'd2) ? -ms : ms;
	endfunction

	// 3*exp(-25*(x-0.6)^2) for a Q30 x, Q16 result; exp(-e/32) then 5 squarings
	function automatic logic [AMP_W-1:0] amp_q16(input logic [63:0] x);
		logic [63:0] d;
		logic [63:0] r;
		logic [63:0] term;
		logic [63:0] v;
		logic signed [63:0] sum;
		logic [AMP_W-1:0] res;
		d = (x > X_PEAK_Q30) ? x - X_PEAK_Q30 : X_PEAK_Q30 - x;
		if (d >= Q30_ONE) begin
			res = '0;
		end else begin
			r    = (64'd25 * ((d * d) >> 30)) >> 5;
			term = Q30_ONE;
			sum  = $signed(Q30_ONE);
			term = ((term * r) >> 30) / 64'd1;  sum = sum - $signed(term);
			term = ((term * r) >> 30) / 64'd2;  sum = sum + $signed(term);
			term = ((term * r) >> 30) / 64'd3;  sum = sum - $signed(term);
			term = ((term * r) >> 30) / 64'd4;  sum = sum + $signed(term);
			term = ((term * r) >> 30) / 64'd5;  sum = sum - $signed(term);
			term = ((term * r) >> 30) / 64'd6;  sum = sum + $signed(term);
			term = ((term * r) >> 30) / 64'd7;  sum = sum - $signed(term);
			term = ((term * r) >> 30) / 64'd8;  sum = sum + $signed(term);
			term = ((term * r) >> 30) / 64'd9;  sum = sum - $signed(term);
			term = ((term * r) >> 30) / 64'd10; sum = sum + $signed(term);
			term = ((term * r) >> 30) / 64'd11; sum = sum - $signed(term);
			term = ((term * r) >> 30) / 64'd12; sum = sum + $signed(term);
			term = ((term * r) >> 30) / 64'd13; sum = sum - $signed(term);
			term = ((term * r) >> 30) / 64'd14; sum = sum + $signed(term);
			term = ((term * r) >> 30) / 64'd15; sum = sum - $signed(term);
			term = ((term * r) >> 30) / 64'd16; sum = sum + $signed(term);
			if (sum < 0)
				sum = 0;
			if (sum > $signed(Q30_ONE))
				sum = $signed(Q30_ONE);
			v = $unsigned(sum);
			for (int k = 0; k < 5; k++) begin
				v = (v * v + (Q30_ONE >> 1)) >> 30;
			end
			res = AMP_W'((64'd3 * v + 64'd8192) >> 14);
		end
		return res;
	endfunction

endpackage

// ===== hdl/diffusion_stencil_rhs_unit.sv =====
// ----------------------------------------------------------------------------
// diffusion_stencil_rhs_unit
// Five-point diffusion right-hand side with source, one grid point per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: drive center, the four neighbors, column and row and raise
//   start; the beat is taken on a rising edge with start high and busy low.
//   Result beat: done is high for one cycle with rate and clipped valid.
//   The receiver cannot hold results off; every result is shown once.
// Pipeline and throughput:
//   Once busy is low, a new point can be taken every cycle. Each point
//   passes the 9-stage pipeline: table lookup, edge and source products,
//   second differences, spacing multiplies, sum, magnitude, diffusion
//   multiply, recombine, saturate.
// Configuration:
//   cfg_we writes cfg_data into the register picked by cfg_idx on the same
//   edge; write only while no point is in flight.
// Reset:
//   arst_n clears the pipeline valid bits and loads the register defaults.
//   busy is high during reset and drops on the first clock after it.
// ----------------------------------------------------------------------------
`include "diffusion_stencil_rhs_unit_assert.svh"

module diffusion_stencil_rhs_unit #(
	parameter int GRID_COLS = 64,
	parameter int GRID_ROWS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [dsr_pkg::VAL_W-1:0]    center,
	input  logic signed [dsr_pkg::VAL_W-1:0]    left_val,
	input  logic signed [dsr_pkg::VAL_W-1:0]    right_val,
	input  logic signed [dsr_pkg::VAL_W-1:0]    up_val,
	input  logic signed [dsr_pkg::VAL_W-1:0]    down_val,
	input  logic [dsr_pkg::IDX_W-1:0]           column,
	input  logic [dsr_pkg::IDX_W-1:0]           row,
	input  logic                                cfg_we,
	input  dsr_pkg::cfg_idx_t                   cfg_idx,
	input  logic [dsr_pkg::COEF_W-1:0]          cfg_data,
	output logic                                done,
	output logic signed [dsr_pkg::RATE_W-1:0]   rate,
	output logic                                clipped
);
	import dsr_pkg::*;

	logic [COEF_W-1:0]       diff_coeff_q;
	logic [COEF_W-1:0]       inv_hx_sq_q;
	logic [COEF_W-1:0]       inv_hy_sq_q;
	logic [HX_W-1:0]         two_hx_q;
	logic                    busy_q;
	logic [LAT-1:0]          vld_q;

	logic signed [NEUM_W-1:0] neum_s2;
	logic signed [SRC_W-1:0]  src_s8;
	mag_t                     mag_s6;
	logic signed [RATE_W-1:0] rate_s9;
	logic                     clipped_s9;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_coeff_q <= DIFF_RST;
			inv_hx_sq_q  <= INV_HX_RST;
			inv_hy_sq_q  <= INV_HY_RST;
			two_hx_q     <= TWO_HX_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_DIFF:   diff_coeff_q <= cfg_data;
				CFG_INV_HX: inv_hx_sq_q  <= cfg_data;
				CFG_INV_HY: inv_hy_sq_q  <= cfg_data;
				CFG_TWO_HX: two_hx_q     <= cfg_data[HX_W-1:0];
				default: ;
			endcase
		end
	end

	// beat valid travels alongside the datapath stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			vld_q  <= '0;
		end else begin
			busy_q <= 1'b0;
			vld_q  <= {vld_q[LAT-2:0], start && !busy_q};
		end
	end

	dsr_coef #(
		.GRID_COLS (GRID_COLS),
		.GRID_ROWS (GRID_ROWS)
	) u_coef (
		.clk     (clk),
		.row     (row),
		.column  (column),
		.two_hx  (two_hx_q),
		.neum_s2 (neum_s2),
		.src_s8  (src_s8)
	);

	dsr_lap #(
		.GRID_COLS (GRID_COLS)
	) u_lap (
		.clk       (clk),
		.center    (center),
		.left_val  (left_val),
		.right_val (right_val),
		.up_val    (up_val),
		.down_val  (down_val),
		.column    (column),
		.neum_s2   (neum_s2),
		.inv_hx_sq (inv_hx_sq_q),
		.inv_hy_sq (inv_hy_sq_q),
		.mag_s6    (mag_s6)
	);

	dsr_scale u_scale (
		.clk        (clk),
		.diff_coeff (diff_coeff_q),
		.mag_s6     (mag_s6),
		.src_s8     (src_s8),
		.rate_s9    (rate_s9),
		.clipped_s9 (clipped_s9)
	);

	assign busy    = busy_q;
	assign done    = vld_q[LAT-1];
	assign rate    = rate_s9;
	assign clipped = clipped_s9;

	// every accepted beat comes out as a done strobe at the end of the valid pipeline
	`DSR_ASSERT_SAME(a_done_latency, 1'b1, done == $past(start && !busy, LAT), "late strobe")
	// a clipped result sits on one of the limits
	`DSR_ASSERT_SAME(a_clip_limit, done && clipped, rate == RATE_MAX || rate == RATE_MIN, "bad clip")
	// once ready, the pipeline never blocks
	`DSR_ASSERT_NEXT(a_busy_low, !busy, !busy, "busy rose after reset")

endmodule

// ===== hdl/dsr_coef.sv =====
// ----------------------------------------------------------------------------
// dsr_coef
// Table lookups by row and column, Neumann edge term and source term.
// The source term is delayed to line up with the scaled Laplacian.
// ----------------------------------------------------------------------------
module dsr_coef #(
	parameter int GRID_COLS = 64,
	parameter int GRID_ROWS = 64
) (
	input  logic                                 clk,
	input  logic [dsr_pkg::IDX_W-1:0]            row,
	input  logic [dsr_pkg::IDX_W-1:0]            column,
	input  logic [dsr_pkg::HX_W-1:0]             two_hx,
	output logic signed [dsr_pkg::NEUM_W-1:0]    neum_s2,
	output logic signed [dsr_pkg::SRC_W-1:0]     src_s8
);
	import dsr_pkg::*;

	logic signed [TRIG_W-1:0] edge_tab [ROM_SIZE];
	logic signed [TRIG_W-1:0] wave_tab [ROM_SIZE];
	logic [AMP_W-1:0]         amp_tab  [ROM_SIZE];

	logic signed [TRIG_W-1:0] edge_s1;
	logic signed [TRIG_W-1:0] wave_s1;
	logic [AMP_W-1:0]         amp_s1;

	logic signed [HX_W+TRIG_W:0]        neum_prod;
	logic signed [AMP_W+TRIG_W:0]       src_prod;
	logic signed [SRC_W-1:0]            src_s2;
	logic signed [SRC_W-1:0]            src_s3;
	logic signed [SRC_W-1:0]            src_s4;
	logic signed [SRC_W-1:0]            src_s5;
	logic signed [SRC_W-1:0]            src_s6;
	logic signed [SRC_W-1:0]            src_s7;

	// constant tables, built at elaboration
	for (genvar i = 0; i < ROM_SIZE; i++) begin : g_rom
		localparam longint unsigned EDGE_NUM = (3 * i) % GRID_ROWS;
		localparam longint unsigned WAVE_NUM = i % GRID_ROWS;
		localparam logic [63:0] EDGE_PH = (64'(EDGE_NUM) << 32) / 64'(GRID_ROWS);
		localparam logic [63:0] WAVE_PH = (64'(WAVE_NUM) << 32) / 64'(GRID_ROWS);
		localparam logic [63:0] X_Q30   = (64'(i) << 30) / 64'(GRID_COLS - 1);
		localparam logic signed [TRIG_W-1:0] EDGE_V = sine_q16(EDGE_PH);
		localparam logic signed [TRIG_W-1:0] WAVE_V = sine_q16(WAVE_PH);
		localparam logic [AMP_W-1:0]         AMP_V  = amp_q16(X_Q30);
		assign edge_tab[i] = EDGE_V;
		assign wave_tab[i] = WAVE_V;
		assign amp_tab[i]  = AMP_V;
	end

	// products, floor to Q16
	assign neum_prod = $signed({1'b0, two_hx}) * edge_s1;
	assign src_prod  = $signed({1'b0, amp_s1}) * wave_s1;

	// s1 lookup, s2 products, s3..s8 source delay
	always_ff @(posedge clk) begin
		edge_s1 <= edge_tab[row];
		wave_s1 <= wave_tab[row];
		amp_s1  <= amp_tab[column];
		neum_s2 <= neum_prod[NEUM_W+Q_FRAC-1:Q_FRAC];
		src_s2  <= src_prod[SRC_W+Q_FRAC-1:Q_FRAC];
		src_s3  <= src_s2;
		src_s4  <= src_s3;
		src_s5  <= src_s4;
		src_s6  <= src_s5;
		src_s7  <= src_s6;
		src_s8  <= src_s7;
	end

endmodule

// ===== hdl/dsr_lap.sv =====
// ----------------------------------------------------------------------------
// dsr_lap
// Boundary handling, second differences and spacing scale of the five-point
// stencil. Produces the sum in sign-magnitude form.
// ----------------------------------------------------------------------------
module dsr_lap #(
	parameter int GRID_COLS = 64
) (
	input  logic                                clk,
	input  logic signed [dsr_pkg::VAL_W-1:0]    center,
	input  logic signed [dsr_pkg::VAL_W-1:0]    left_val,
	input  logic signed [dsr_pkg::VAL_W-1:0]    right_val,
	input  logic signed [dsr_pkg::VAL_W-1:0]    up_val,
	input  logic signed [dsr_pkg::VAL_W-1:0]    down_val,
	input  logic [dsr_pkg::IDX_W-1:0]           column,
	input  logic signed [dsr_pkg::NEUM_W-1:0]   neum_s2,
	input  logic [dsr_pkg::COEF_W-1:0]          inv_hx_sq,
	input  logic [dsr_pkg::COEF_W-1:0]          inv_hy_sq,
	output dsr_pkg::mag_t                       mag_s6
);
	import dsr_pkg::*;

	localparam logic [31:0] LAST_COL = 32'(GRID_COLS - 1);

	logic signed [VAL_W-1:0] c_s1, l_s1, r_s1, u_s1, d_s1;
	logic signed [VAL_W-1:0] c_s2, l_s2, r_s2, u_s2, d_s2;
	logic                    col0_s1, last_s1, col0_s2, last_s2;

	logic signed [LX_W-1:0]  ul, ur, lx;
	logic signed [LY_W-1:0]  ly;
	logic signed [LX_W-1:0]  lx_s3;
	logic signed [LY_W-1:0]  ly_s3;
	logic signed [PX_W-1:0]  px_s4;
	logic signed [PY_W-1:0]  py_s4;
	logic signed [SUM_W-1:0] sum_s5;
	logic signed [SUM_W-1:0] abs_v;

	// ghost points: Neumann on the first column, mirror on the last
	always_comb begin
		ul = col0_s2 ? LX_W'(r_s2) + LX_W'(neum_s2) : LX_W'(l_s2);
		ur = last_s2 ? LX_W'(l_s2) : LX_W'(r_s2);
		lx = ul - (LX_W'(c_s2) <<< 1) + ur;
		ly = LY_W'(u_s2) - (LY_W'(c_s2) <<< 1) + LY_W'(d_s2);
	end

	assign abs_v = sum_s5[SUM_W-1] ? -sum_s5 : sum_s5;

	always_ff @(posedge clk) begin
		// s1: capture beat, decode edge columns
		c_s1    <= center;
		l_s1    <= left_val;
		r_s1    <= right_val;
		u_s1    <= up_val;
		d_s1    <= down_val;
		col0_s1 <= (column == '0);
		last_s1 <= (32'(column) == LAST_COL);
		// s2: wait for the Neumann term
		c_s2    <= c_s1;
		l_s2    <= l_s1;
		r_s2    <= r_s1;
		u_s2    <= u_s1;
		d_s2    <= d_s1;
		col0_s2 <= col0_s1;
		last_s2 <= last_s1;
		// s3: second differences
		lx_s3   <= lx;
		ly_s3   <= ly;
		// s4: spacing scale
		px_s4   <= lx_s3 * $signed({1'b0, inv_hx_sq});
		py_s4   <= ly_s3 * $signed({1'b0, inv_hy_sq});
		// s5: combine directions
		sum_s5  <= px_s4 + SUM_W'(py_s4);
		// s6: sign-magnitude
		mag_s6.neg <= sum_s5[SUM_W-1];
		mag_s6.mag <= abs_v[MAG_W-1:0];
	end

endmodule

// ===== hdl/dsr_scale.sv =====
// ----------------------------------------------------------------------------
// dsr_scale
// Diffusion constant multiply in two partial products, Q16 rounding toward
// minus infinity, source add and 48-bit saturation.
// ----------------------------------------------------------------------------
module dsr_scale (
	input  logic                                clk,
	input  logic [dsr_pkg::COEF_W-1:0]          diff_coeff,
	input  dsr_pkg::mag_t                       mag_s6,
	input  logic signed [dsr_pkg::SRC_W-1:0]    src_s8,
	output logic signed [dsr_pkg::RATE_W-1:0]   rate_s9,
	output logic                                clipped_s9
);
	import dsr_pkg::*;

	localparam int VW = Q_W + 2;

	logic [PH_W-1:0]         ph_s7;
	logic [PL_W-1:0]         pl_s7;
	logic                    neg_s7;
	logic                    huge_s8;
	logic                    neg_s8;
	logic [Q_W-1:0]          q_s8;

	logic signed [VW-1:0]    qx;
	logic signed [VW-1:0]    srcx;
	logic signed [VW-1:0]    val;
	logic                    ovf;
	logic signed [RATE_W-1:0] rate_d;
	logic                    clip_d;

	// source add and clamp
	always_comb begin
		qx   = $signed({2'b00, q_s8});
		srcx = VW'(src_s8);
		val  = neg_s8 ? srcx - qx : srcx + qx;
		ovf  = (val[VW-1:RATE_W-1] != '0) && (val[VW-1:RATE_W-1] != '1);
		if (huge_s8) begin
			rate_d = neg_s8 ? RATE_MIN : RATE_MAX;
			clip_d = 1'b1;
		end else if (ovf) begin
			rate_d = val[VW-1] ? RATE_MIN : RATE_MAX;
			clip_d = 1'b1;
		end else begin
			rate_d = val[RATE_W-1:0];
			clip_d = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		// s7: partial products on the high and low magnitude words
		ph_s7      <= diff_coeff * mag_s6.mag[MAG_W-1:LO_W];
		pl_s7      <= diff_coeff * mag_s6.mag[LO_W-1:0];
		neg_s7     <= mag_s6.neg;
		// s8: recombine, round negative values away from zero
		huge_s8    <= |ph_s7[PH_W-1:LO_W];
		q_s8       <= Q_W'({ph_s7[LO_W-1:0], {Q_FRAC{1'b0}}})
		            + Q_W'(pl_s7[PL_W-1:Q_FRAC])
		            + Q_W'(neg_s7 && (|pl_s7[Q_FRAC-1:0]));
		neg_s8     <= neg_s7;
		// s9: result
		rate_s9    <= rate_d;
		clipped_s9 <= clip_d;
	end

endmodule
